/* hdl/rgb_to_hsl_converter_macros.svh */
// Assertion macros shared by the RGB to HSL converter files.
`ifndef RGB_TO_HSL_CONVERTER_MACROS_SVH
`define RGB_TO_HSL_CONVERTER_MACROS_SVH

// Concurrent check on every rising clock edge, switched off while in reset.
`define RTH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check on every rising clock edge, reset included.
`define RTH_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/rth_pkg.sv */
// Shared constants, types and the divider step for the RGB to HSL converter.
`timescale 1ns / 1ps

package rth_pkg;

    // Field widths of the pixel and result words.
    localparam int CH_W  = 8;
    localparam int HUE_W = 15;
    localparam int SAT_W = 16;
    localparam int LIT_W = 16;

    // Hue numerator is below 6 * 255, so it fits in 11 bits.
    localparam int NUM_W = 11;

    // Quotient bits resolved by each divider stage.
    localparam int DIV_BPS = 4;

    // Default number of fraction bits of the hue in degrees.
    localparam int HUE_FRAC_BITS_DEF = 6;

    // Result of one restoring division step.
    typedef struct packed {
        logic [CH_W-1:0] rem;
        logic            q;
    } div_bit_t;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    // The remainder stays below the divisor, so it never needs a ninth bit.
    function automatic div_bit_t div_bit(input logic [CH_W-1:0] rem,
                                         input logic            din,
                                         input logic [CH_W-1:0] dvs);
        logic [CH_W:0] t;
        div_bit_t      res;
        t = {rem, din};
        if (t >= {1'b0, dvs})
        begin
            res.rem = CH_W'(t - {1'b0, dvs});
            res.q   = 1'b1;
        end
        else
        begin
            res.rem = t[CH_W-1:0];
            res.q   = 1'b0;
        end
        return res;
    endfunction

endpackage

/* hdl/rth_pix_if.sv */
// Valid/ready channel that carries one RGB pixel word.
`timescale 1ns / 1ps

interface rth_pix_if import rth_pkg::*; ();

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);

endinterface

/* hdl/rth_hsl_if.sv */
// Valid/ready channel that carries one HSL result word.
`timescale 1ns / 1ps

interface rth_hsl_if import rth_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [LIT_W-1:0] lightness;

    modport source (output valid, output hue, output saturation, output lightness,
                    input ready);
    modport sink (input valid, input hue, input saturation, input lightness,
                  output ready);

endinterface

/* hdl/rgb_to_hsl_converter.sv */
// Pipelined RGB to HSL converter: one 8-bit RGB word in, one fixed-point HSL word out.
//
//   channel | dir | word contents
//   --------+-----+------------------------------------------------------
//   pix     | in  | red, green, blue (8 bits each, unsigned)
//   hsl     | out | hue (15 bits, 1/64 degree), saturation and lightness (Q0.16)
//
// One word enters per clock while the output is not stalled; a word passes stage 1,
// stage 2 and NSTAGE divider stages, NSTAGE = ceil(max(16, HUE_FRAC_BITS + 9) / 4).
// The depth is set by the two restoring dividers, which resolve four quotient
// bits per stage. Reset clears only the stage valid bits.
// Every stage has its own ready, so a stalled output lets empty stages fill
// and the input keeps taking words until the whole pipeline is occupied.
`timescale 1ns / 1ps
`include "rgb_to_hsl_converter_macros.svh"

module rgb_to_hsl_converter
    import rth_pkg::*;
#(
    parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    rth_pix_if.sink       pix,
    rth_hsl_if.source     hsl
);

    // Hue scale is 60 degrees in hue units.
    localparam int HS_W   = HUE_FRAC_BITS + 6;
    localparam int HP_W   = HS_W + NUM_W;
    localparam int HQ_W   = HUE_FRAC_BITS + 9;
    localparam int QMAX   = (HQ_W > SAT_W) ? HQ_W : SAT_W;
    localparam int NSTAGE = (QMAX + DIV_BPS - 1) / DIV_BPS;
    localparam int QP     = NSTAGE * DIV_BPS;
    localparam int DW     = QP + CH_W;
    localparam logic [HS_W-1:0] HUE_SCALE = HS_W'(60) << HUE_FRAC_BITS;

    // Contents of one divider stage: both divisions travel side by side.
    typedef struct packed {
        logic             zero;
        logic [LIT_W-1:0] light;
        logic [CH_W-1:0]  hue_div;
        logic [CH_W-1:0]  sat_div;
        logic [CH_W-1:0]  hue_rem;
        logic [QP-1:0]    hue_acc;
        logic [CH_W-1:0]  sat_rem;
        logic [QP-1:0]    sat_acc;
    } div_stage_t;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [CH_W-1:0]   s1_d_reg;
    logic [CH_W:0]     s1_sum_reg;
    logic [NUM_W-1:0]  s1_num_reg;
    logic [CH_W-1:0]   s1_d_next;
    logic [CH_W:0]     s1_sum_next;
    logic [NUM_W-1:0]  s1_num_next;
    logic              s1_adv;

    div_stage_t        dv_reg  [0:NSTAGE];
    div_stage_t        dv_next [0:NSTAGE];
    logic [NSTAGE:0]   dv_valid_reg;
    logic [NSTAGE:0]   dv_valid_next;
    logic [NSTAGE:0]   adv;

    logic [CH_W-1:0]   mx;
    logic [CH_W-1:0]   mn;
    logic [HP_W-1:0]   hue_prod;
    logic [DW-1:0]     hue_dvd;
    logic [DW-1:0]     sat_dvd;
    logic [CH_W:0]     lit_prod_hi;
    logic [CH_W+8:0]   lit_prod;

    // Stage advance chain: a stage moves when it is empty or its successor moves.
    assign adv[NSTAGE] = !dv_valid_reg[NSTAGE] || hsl.ready;
    genvar k;
    generate
        for (k = 0; k < NSTAGE; k++)
        begin : g_adv
            assign adv[k] = !dv_valid_reg[k] || adv[k+1];
        end
    endgenerate
    assign s1_adv    = !s1_valid_reg || adv[0];
    assign pix.ready = s1_adv;

    // Stage 1: max, min, spread, sum and the hue numerator.
    always_comb
    begin
        mx = pix.red;
        mn = pix.red;
        if (pix.green > mx) mx = pix.green;
        if (pix.blue > mx) mx = pix.blue;
        if (pix.green < mn) mn = pix.green;
        if (pix.blue < mn) mn = pix.blue;
        s1_d_next   = mx - mn;
        s1_sum_next = {1'b0, mx} + {1'b0, mn};
        if (pix.red == mx)
        begin
            s1_num_next = NUM_W'(pix.green) - NUM_W'(pix.blue);
            if (pix.green < pix.blue)
            begin
                s1_num_next = s1_num_next + NUM_W'({s1_d_next, 2'b00})
                            + NUM_W'({s1_d_next, 1'b0});
            end
        end
        else if (pix.green == mx)
        begin
            s1_num_next = NUM_W'({s1_d_next, 1'b0}) + NUM_W'(pix.blue) - NUM_W'(pix.red);
        end
        else
        begin
            s1_num_next = NUM_W'({s1_d_next, 2'b00}) + NUM_W'(pix.red) - NUM_W'(pix.green);
        end
        s1_valid_next = s1_adv ? pix.valid : s1_valid_reg;
    end

    // Stage 2: lightness, divisors and the two dividends.
    always_comb
    begin
        // Lightness is 257 * sum / 2, since 65535 / 510 is exactly 257 / 2.
        lit_prod_hi = s1_sum_reg;
        lit_prod    = {lit_prod_hi, 8'h00} + (CH_W+9)'(s1_sum_reg);
        hue_prod    = HP_W'(HUE_SCALE) * HP_W'(s1_num_reg);
        hue_dvd     = DW'(hue_prod);
        sat_dvd     = DW'({s1_d_reg, 16'h0000}) - DW'(s1_d_reg);

        dv_next[0].zero    = (s1_d_reg == '0);
        dv_next[0].light   = lit_prod[LIT_W:1];
        dv_next[0].hue_div = s1_d_reg;
        if (s1_sum_reg[CH_W])
        begin
            dv_next[0].sat_div = CH_W'(9'd510 - s1_sum_reg);
        end
        else
        begin
            dv_next[0].sat_div = s1_sum_reg[CH_W-1:0];
        end
        dv_next[0].hue_rem = hue_dvd[DW-1:QP];
        dv_next[0].hue_acc = hue_dvd[QP-1:0];
        dv_next[0].sat_rem = sat_dvd[DW-1:QP];
        dv_next[0].sat_acc = sat_dvd[QP-1:0];
        dv_valid_next[0]   = adv[0] ? s1_valid_reg : dv_valid_reg[0];
    end

    // Divider stages: each resolves DIV_BPS quotient bits of both divisions.
    // The accumulator shifts dividend bits out at the top and quotient bits in.
    generate
        for (k = 1; k <= NSTAGE; k++)
        begin : g_div
            always_comb
            begin
                div_stage_t x;
                div_bit_t   hb;
                div_bit_t   sb;
                x = dv_reg[k-1];
                for (int j = 0; j < DIV_BPS; j++)
                begin
                    hb = div_bit(x.hue_rem, x.hue_acc[QP-1], x.hue_div);
                    sb = div_bit(x.sat_rem, x.sat_acc[QP-1], x.sat_div);
                    x.hue_rem = hb.rem;
                    x.hue_acc = {x.hue_acc[QP-2:0], hb.q};
                    x.sat_rem = sb.rem;
                    x.sat_acc = {x.sat_acc[QP-2:0], sb.q};
                end
                dv_next[k]       = x;
                dv_valid_next[k] = adv[k] ? dv_valid_reg[k-1] : dv_valid_reg[k];
            end

            always_ff @(posedge clk)
            begin
                if (adv[k] && dv_valid_reg[k-1])
                begin
                    dv_reg[k] <= dv_next[k];
                end
            end
        end
    endgenerate

    // Valid bits of every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            dv_valid_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            dv_valid_reg <= dv_valid_next;
        end
    end

    // Payload of the first two stages.
    always_ff @(posedge clk)
    begin
        if (pix.valid && s1_adv)
        begin
            s1_d_reg   <= s1_d_next;
            s1_sum_reg <= s1_sum_next;
            s1_num_reg <= s1_num_next;
        end
        if (adv[0] && s1_valid_reg)
        begin
            dv_reg[0] <= dv_next[0];
        end
    end

    // Result word; a grey pixel forces hue and saturation to zero.
    assign hsl.valid      = dv_valid_reg[NSTAGE];
    assign hsl.hue        = dv_reg[NSTAGE].zero ? '0 : dv_reg[NSTAGE].hue_acc[HUE_W-1:0];
    assign hsl.saturation = dv_reg[NSTAGE].zero ? '0 : dv_reg[NSTAGE].sat_acc[SAT_W-1:0];
    assign hsl.lightness  = dv_reg[NSTAGE].light;

    // The result word stays invalid for as long as reset is held.
    `RTH_ASSERT_ALWAYS(a_no_word_in_reset, !rst_n |-> !hsl.valid, "result valid during reset")

    // An accepted pixel always lands in the first stage.
    `RTH_ASSERT(a_accept_lands, (pix.valid && pix.ready) |=> s1_valid_reg, "accepted pixel lost")

    // Both quotients fit their width: the top of each dividend is below its divisor.
    `RTH_ASSERT(a_div_entry_fits, (dv_valid_reg[0] && !dv_reg[0].zero) |-> ((dv_reg[0].hue_rem < dv_reg[0].hue_div) && (dv_reg[0].sat_rem < dv_reg[0].sat_div)), "dividend too large for quotient width")

    // The last divider stage still holds proper remainders.
    `RTH_ASSERT(a_div_exit_rem, (dv_valid_reg[NSTAGE] && !dv_reg[NSTAGE].zero) |-> ((dv_reg[NSTAGE].hue_rem < dv_reg[NSTAGE].hue_div) && (dv_reg[NSTAGE].sat_rem < dv_reg[NSTAGE].sat_div)), "remainder not below divisor")

endmodule
